// File: sv/rllt_pkg.sv
// Shared constants, types and command/status structs for the run-length line table.
package rllt_pkg;

  localparam int RUN_DEPTH = 256;
  localparam int MAX_BYTES = 4096;

  localparam int LINE_W  = 16;
  localparam int IDX_W   = 12;
  localparam int RUN_AW  = $clog2(RUN_DEPTH);
  localparam int RUNS_W  = $clog2(RUN_DEPTH + 1);
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);
  localparam int COUNT_W = BYTES_W;
  localparam int ENTRY_W = LINE_W + COUNT_W;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture accepted item, clear walk
    logic append;    // perform append, set result
    logic miss;      // result: index not found
    logic advance;   // bump walk address
    logic accum;     // add fetched count to running sum
    logic hit;       // result: line of fetched run
    logic load_out;  // move result into output register
  } rllt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic out_of_range;
    logic hit;
    logic out_free;
  } rllt_sts_t;

endpackage

// File: sv/rllt_in_if.sv
// Input channel: valid/ready handshake with append/query item payload.
interface rllt_in_if;
  import rllt_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [LINE_W-1:0]   line_number;
  logic [IDX_W-1:0]    query_index;

  modport source (output valid, action, line_number, query_index, input ready);
  modport sink   (input valid, action, line_number, query_index, output ready);
endinterface

// File: sv/rllt_out_if.sv
// Output channel: valid/ready handshake with status and line result.
interface rllt_out_if;
  import rllt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [LINE_W-1:0] line_out;

  modport source (output valid, status, line_out, input ready);
  modport sink   (input valid, status, line_out, output ready);
endinterface

// File: sv/rllt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rllt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rllt_ctrl.sv
// Controller state machine: accept, execute, walk runs, deliver result.
module rllt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rllt_pkg::rllt_sts_t sts,
  output rllt_pkg::rllt_cmd_t cmd
);
  import rllt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.is_query) begin
          cmd.append = 1'b1;
          state_next = S_DONE;
        end else if (sts.out_of_range) begin
          cmd.miss   = 1'b1;
          state_next = S_DONE;
        end else begin
          // first run is being fetched at this edge
          cmd.advance = 1'b1;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        cmd.accum   = 1'b1;
        cmd.advance = 1'b1;
        if (sts.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !sts.out_of_range)
    else $error("walking a query that is out of range");

  assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == S_EXEC))
    else $error("accepted item did not reach execute");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && sts.out_free) |=> in_ready)
    else $error("controller did not return to idle after delivery");

endmodule

// File: sv/rllt_dp.sv
// Datapath: run memory, counters, last-run copy, walk sum and output register.
module rllt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_action,
  input  logic [rllt_pkg::LINE_W-1:0] in_line,
  input  logic [rllt_pkg::IDX_W-1:0]  in_idx,
  input  rllt_pkg::rllt_cmd_t         cmd,
  output rllt_pkg::rllt_sts_t         sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [rllt_pkg::LINE_W-1:0] out_line
);
  import rllt_pkg::*;

  // latched item
  logic                item_action;
  logic [LINE_W-1:0]   item_line;
  logic [IDX_W-1:0]    item_idx;

  // table state
  logic [RUNS_W-1:0]   runs_used;
  logic [BYTES_W-1:0]  bytes_recorded;
  logic [LINE_W-1:0]   last_line;
  logic [COUNT_W-1:0]  last_count;

  // walk
  logic [RUN_AW-1:0]   walk_addr;
  logic [BYTES_W-1:0]  sum;
  logic [BYTES_W-1:0]  sum_next;
  logic [BYTES_W-1:0]  idx_ext;

  // pending result
  status_t             res_status;
  logic [LINE_W-1:0]   res_line;

  // memory port
  logic                ram_we;
  logic [RUN_AW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [LINE_W-1:0]   q_line;
  logic [COUNT_W-1:0]  q_count;

  // append decode
  logic                bytes_full;
  logic                table_full;
  logic                extend;
  logic [RUNS_W-1:0]   last_idx;
  logic [COUNT_W-1:0]  inc_count;
  status_t             app_status;

  rllt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RUN_DEPTH)
  ) u_runs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_addr),
    .rdata (ram_rdata)
  );

  assign q_line   = ram_rdata[ENTRY_W-1 -: LINE_W];
  assign q_count  = ram_rdata[COUNT_W-1:0];
  assign idx_ext  = BYTES_W'(item_idx);
  assign sum_next = sum + q_count;

  assign bytes_full = (bytes_recorded >= BYTES_W'(MAX_BYTES));
  assign table_full = (runs_used >= RUNS_W'(RUN_DEPTH));
  assign extend     = (runs_used != '0) && (last_line == item_line);
  assign last_idx   = runs_used - RUNS_W'(1);
  assign inc_count  = last_count + COUNT_W'(1);

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = runs_used[RUN_AW-1:0];
    ram_wdata  = {item_line, COUNT_W'(1)};
    app_status = ST_OK;
    if (bytes_full) begin
      app_status = ST_FULL;
    end else if (extend) begin
      ram_we    = cmd.append;
      ram_waddr = last_idx[RUN_AW-1:0];
      ram_wdata = {item_line, inc_count};
    end else if (table_full) begin
      app_status = ST_FULL;
    end else begin
      ram_we = cmd.append;
    end
  end

  assign sts.is_query     = (item_action == ACT_QUERY);
  assign sts.out_of_range = (idx_ext >= bytes_recorded);
  assign sts.hit          = (sum_next > idx_ext);
  assign sts.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      runs_used      <= '0;
      bytes_recorded <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.append && app_status == ST_OK) begin
        bytes_recorded <= bytes_recorded + BYTES_W'(1);
        if (!extend) begin
          runs_used <= runs_used + RUNS_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_action <= in_action;
      item_line   <= in_line;
      item_idx    <= in_idx;
      walk_addr   <= '0;
      sum         <= '0;
    end else begin
      if (cmd.advance) begin
        walk_addr <= walk_addr + RUN_AW'(1);
      end
      if (cmd.accum) begin
        sum <= sum_next;
      end
    end
    if (cmd.append) begin
      res_status <= app_status;
      res_line   <= '0;
      if (app_status == ST_OK) begin
        last_line  <= item_line;
        last_count <= extend ? inc_count : COUNT_W'(1);
      end
    end
    if (cmd.miss) begin
      res_status <= ST_NOT_FOUND;
      res_line   <= '0;
    end
    if (cmd.hit) begin
      res_status <= ST_OK;
      res_line   <= q_line;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_line   <= res_line;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    bytes_recorded <= BYTES_W'(MAX_BYTES))
    else $error("byte count past capacity");

  assert property (@(posedge clk) disable iff (rst)
    runs_used <= RUNS_W'(RUN_DEPTH) && BYTES_W'(runs_used) <= bytes_recorded)
    else $error("run count inconsistent");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result not presented after load");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.append && app_status == ST_FULL) |=> $stable(bytes_recorded) && $stable(runs_used))
    else $error("refused append changed table state");

endmodule

// File: sv/run_length_line_table.sv
// Run-length line table top: (line, count) run store with append and byte-index query.
// Flow: an append or an out-of-range query goes from execute straight to done; a query
//   in range walks the runs from run 0 until the hit, then goes to done to raise out valid.
// Items are handled one at a time; a new item is taken only once the controller is idle,
//   and the walk reads one run per cycle from the single-read-port run memory.
// Reset (rst, synchronous): run and byte counters cleared, no result pending; run memory
//   is left as is, since entries are only read below the run count.
module run_length_line_table (
  input logic        clk,
  input logic        rst,
  rllt_in_if.sink    in_item,
  rllt_out_if.source out_item
);
  import rllt_pkg::*;

  rllt_cmd_t cmd;
  rllt_sts_t sts;

  // Control: one item in flight; idle state is the only one that takes a new item.
  rllt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: appends update the last run copy and memory together; queries
  // walk the runs summing counts until the sum passes the index. The output
  // register frees the controller once a result is parked there.
  rllt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_action  (in_item.action),
    .in_line    (in_item.line_number),
    .in_idx     (in_item.query_index),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .out_status (out_item.status),
    .out_line   (out_item.line_out)
  );

endmodule
